/* rtl/idb_pkg.sv */
// Shared types and constants for the inverse depth back-projection block.
package idb_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int DimW      = 13;
  localparam int PosW      = 12;
  localparam int QuoW      = 38;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FX     = 3'd2;
  localparam logic [2:0] REG_FY     = 3'd3;
  localparam logic [2:0] REG_CX     = 3'd4;
  localparam logic [2:0] REG_CY     = 3'd5;

  // One kept pixel as queued between front and back.
  typedef struct packed {
    logic signed [23:0] inv_depth;
    logic signed [23:0] inv_depth_var;
    logic [19:0]        intensity;
    logic signed [23:0] gradient_x;
    logic signed [23:0] gradient_y;
    logic [PosW-1:0]    x;
    logic [PosW-1:0]    y;
    logic [23:0]        pixel_index;
    logic [23:0]        point_number;
  } idb_entry_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } idb_intr_t;

endpackage

/* rtl/idb_front.sv */
// Front end: tracks pixel position, drops border and invalid pixels, queues the rest.
module idb_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  logic [idb_pkg::DimW-1:0] w,
  input  logic [idb_pkg::DimW-1:0] h,
  input  logic [119:0]             tdata,
  output logic                     push,
  output idb_pkg::idb_entry_t      entry
);
  import idb_pkg::*;

  logic [PosW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [23:0]     cnt_r, cnt_nxt;
  logic [DimW-1:0] x1, y1;
  logic            interior, keep, row_end, col_end;
  logic signed [23:0] d, v;
  logic [DimW+PosW-1:0] yw;

  always_comb begin
    d        = tdata[23:0];
    v        = tdata[47:24];
    x1       = {1'b0, x_r} + 13'd1;
    y1       = {1'b0, y_r} + 13'd1;
    interior = (x_r != '0) && (x1 < w) && (y_r != '0) && (y1 < h);
    keep     = interior && (v > 0) && (d != 0);
    row_end  = y1 >= h;
    col_end  = x1 >= w;
    yw       = y_r * w;
    entry.inv_depth     = d;
    entry.inv_depth_var = v;
    entry.intensity     = tdata[67:48];
    entry.gradient_x    = tdata[91:68];
    entry.gradient_y    = tdata[115:92];
    entry.x             = x_r;
    entry.y             = y_r;
    entry.pixel_index   = yw[23:0] + {12'd0, x_r};
    entry.point_number  = cnt_r;
    push = acc && keep;
    x_nxt = x_r;
    y_nxt = y_r;
    cnt_nxt = keep ? cnt_r + 24'd1 : cnt_r;
    if (row_end) begin
      y_nxt = '0;
      if (col_end) begin
        x_nxt   = '0;
        cnt_nxt = '0;
      end else begin
        x_nxt = x1[PosW-1:0];
      end
    end else begin
      y_nxt = y1[PosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      cnt_r <= '0;
    end else if (acc) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* rtl/idb_queue.sv */
// Two-entry queue between front and back.
module idb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  idb_pkg::idb_entry_t wdata,
  input  logic                pop,
  output idb_pkg::idb_entry_t rdata,
  output logic                full,
  output logic                empty
);
  import idb_pkg::*;

  idb_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/idb_back.sv */
// Back end: serial reciprocal, ray scaling and the output register.
module idb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  idb_pkg::idb_intr_t  intr,
  input  logic                q_empty,
  input  idb_pkg::idb_entry_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [239:0]        out_data
);
  import idb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         st_r, st_nxt;
  idb_entry_t         ent_r;
  logic [5:0]         cnt_r;
  logic [24:0]        rem_r, den_r;
  logic [QuoW-1:0]    num_r, quo_r;
  logic               neg_r;
  logic signed [44:0] rxp_r, ryp_r;
  logic signed [31:0] rx_r, ry_r;
  logic signed [63:0] px_r, py_r;
  logic signed [31:0] depth;
  logic [239:0]       out_r;
  logic [25:0]        trial;
  logic [23:0]        mag;
  logic signed [45:0] rxs, rys;
  logic signed [31:0] sx, sy;

  function automatic logic signed [31:0] clamp32(input logic signed [45:0] v);
    if (v > 46'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -46'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scale(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] r;
    m = p[63] ? 64'd0 - p : p;
    r = (m + 64'd8388608) >> 24;
    if (p[63]) begin
      if (r >= 64'd2147483648) return 32'sh80000000;
      return 32'd0 - r[31:0];
    end
    if (r > 64'd2147483647) return 32'sh7FFFFFFF;
    return r[31:0];
  endfunction

  assign pop       = (st_r == S_IDLE) && !q_empty;
  assign out_valid = st_r == S_OUT;
  assign out_data  = out_r;

  always_comb begin
    trial = {rem_r, num_r[QuoW-1]};
    mag   = q_data.inv_depth[23] ? 24'd0 - q_data.inv_depth : q_data.inv_depth;
    rxs   = $signed(intr.cx) + rxp_r;
    rys   = $signed(intr.cy) + ryp_r;
    if (neg_r) depth = (quo_r >= 38'd2147483648) ? 32'sh80000000 : 32'd0 - quo_r[31:0];
    else       depth = (quo_r > 38'd2147483647) ? 32'sh7FFFFFFF : quo_r[31:0];
    sx = scale(px_r);
    sy = scale(py_r);
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (!q_empty) st_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd0) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_RND;
      S_RND:  st_nxt = S_OUT;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rxp_r <= intr.fx * $signed({1'b0, ent_r.x});
    ryp_r <= intr.fy * $signed({1'b0, ent_r.y});
    rx_r  <= clamp32(rxs);
    ry_r  <= clamp32(rys);
    case (st_r)
      S_IDLE: begin
        ent_r <= q_data;
        neg_r <= q_data.inv_depth[23];
        den_r <= {mag, 1'b0};
        num_r <= {1'b1, 13'd0, mag};
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 6'(QuoW - 1);
      end
      S_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= 25'(trial - {1'b0, den_r});
          quo_r <= {quo_r[QuoW-2:0], 1'b1};
        end else begin
          rem_r <= trial[24:0];
          quo_r <= {quo_r[QuoW-2:0], 1'b0};
        end
        num_r <= {num_r[QuoW-2:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
      end
      S_MUL: begin
        px_r <= depth * rx_r;
        py_r <= depth * ry_r;
      end
      S_RND: begin
        out_r <= {4'd0, ent_r.point_number, ent_r.pixel_index, ent_r.inv_depth_var,
                  ent_r.intensity, ent_r.gradient_y, ent_r.gradient_x, depth, sy, sx};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end
endmodule

/* rtl/inverse_depth_backprojection.sv */
// Top level of the inverse depth back-projection block.
// Takes one pyramid level of pixels, column by column with y fastest, and emits a 3D
// point for every pixel off the one-pixel border with positive variance and nonzero
// inverse depth. The front end tracks position and classifies each pixel in the cycle
// it is accepted; dropped pixels never enter the queue. Kept pixels wait in a two-entry
// queue for the back end, which works on one point at a time: the bit-serial reciprocal
// of inverse depth, then one product stage, one rounding stage and the output register.
// Output throughput is set by the serial divider and out_tready. Configuration writes
// (width, height, intrinsics) are taken on any cycle and must only happen while idle.
module inverse_depth_backprojection (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // inv_depth, inv_depth_var, intensity, gradient_x, gradient_y
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x, point_y, point_z, grad_x_out, grad_y_out, intensity_out,
  // variance_out, pixel_index, point_number
  output logic [239:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import idb_pkg::*;

  logic [DimW-1:0] width_r, height_r, w_eff, h_eff;
  idb_intr_t       intr_r;
  logic            acc, push, pop, full, empty;
  idb_entry_t      f_ent, q_ent;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  // Clamp the size to the supported range.
  always_comb begin
    w_eff = (width_r < 13'd3) ? 13'd3 : (width_r > 13'(MaxWidth) ? 13'(MaxWidth) : width_r);
    h_eff = (height_r < 13'd3) ? 13'd3
          : (height_r > 13'(MaxHeight) ? 13'(MaxHeight) : height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd640;
      height_r <= 13'd480;
      intr_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r   <= cfg_data[DimW-1:0];
        REG_HEIGHT: height_r  <= cfg_data[DimW-1:0];
        REG_FX:     intr_r.fx <= cfg_data;
        REG_FY:     intr_r.fy <= cfg_data;
        REG_CX:     intr_r.cx <= cfg_data;
        REG_CY:     intr_r.cy <= cfg_data;
        default: ;
      endcase
    end
  end

  idb_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .w(w_eff), .h(h_eff),
    .tdata(in_tdata), .push(push), .entry(f_ent)
  );

  idb_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_ent), .pop(pop),
    .rdata(q_ent), .full(full), .empty(empty)
  );

  idb_back u_back (
    .clk(clk), .rst_n(rst_n), .intr(intr_r), .q_empty(empty), .q_data(q_ent),
    .pop(pop), .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata)
  );
endmodule
